>>> rtl/asl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the assembly source lexer
// Lexer modes, result codes, character codes and the queue record layout.
// ----------------------------------------------------------------------------
package asl_pkg;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_IDENT = 4'd1,
        M_ZERO  = 4'd2,
        M_DEC   = 4'd3,
        M_HEX   = 4'd4,
        M_BIN   = 4'd5,
        M_SLASH = 4'd6,
        M_LINE  = 4'd7,
        M_BLOCK = 4'd8,
        M_BSTAR = 4'd9,
        M_HALT  = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_EOL   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    localparam logic TYPE_IDENT = 1'b0;
    localparam logic TYPE_INT   = 1'b1;

    localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
    localparam logic [1:0] ERR_SLASH      = 2'd1;
    localparam logic [1:0] ERR_BLOCK      = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    localparam int TAB_STEP    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t       kind;
        logic        ttype;
        logic [7:0]  tchar;
        logic [15:0] line;
        logic [15:0] col;
        logic [1:0]  err;
    } result_t;

    // one request's worth of results, one or two of them
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage
`default_nettype wire

>>> rtl/asl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asl_front: byte classifier and lexer state
// Takes one byte per cycle while the queue is not full, updates mode and
// position and hands the results it causes to the queue as one record.
// ----------------------------------------------------------------------------
module asl_front #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_stall,
    input  wire logic [7:0]          char_value,
    input  wire logic                end_of_input,
    input  wire logic                q_full,
    output logic                     push,
    output asl_pkg::entry_t          push_entry
);

    localparam int P = POSITION_WIDTH;
    localparam logic [P-1:0] POS_ONE = P'(1);

    asl_pkg::mode_t mode_reg, mode_next;
    logic [P-1:0] line_reg, line_next;
    logic [P-1:0] col_reg, col_next;
    logic [P-1:0] start_reg, start_next;

    logic [15:0] line_c, col_c, start_c;
    logic [P:0]  col_sum, line_sum;
    logic [P-1:0] col_inc, line_inc;
    logic accept;

    logic is_letter, is_dec, is_hex, is_bin, is_blank;
    logic in_token, tok_type;
    asl_pkg::mode_t cont_mode;

    logic idle_emit;
    asl_pkg::result_t idle_rec;
    asl_pkg::mode_t idle_mode;
    logic [P-1:0] idle_line, idle_col, idle_start;

    logic [1:0] n_res;
    asl_pkg::result_t rec0, rec1;

    function automatic asl_pkg::result_t make_rec(
        asl_pkg::kind_t kind, logic ttype, logic [7:0] ch,
        logic [15:0] line, logic [15:0] col, logic [1:0] err);
        asl_pkg::result_t r;
        r.kind  = kind;
        r.ttype = ttype;
        r.tchar = ch;
        r.line  = line;
        r.col   = col;
        r.err   = err;
        return r;
    endfunction

    // clamp the position to the 16-bit output fields
    generate
        if (P > 16) begin : g_clamp_wide
            assign line_c  = (|line_reg[P-1:16])  ? 16'hFFFF : line_reg[15:0];
            assign col_c   = (|col_reg[P-1:16])   ? 16'hFFFF : col_reg[15:0];
            assign start_c = (|start_reg[P-1:16]) ? 16'hFFFF : start_reg[15:0];
        end else begin : g_clamp_narrow
            assign line_c  = 16'(line_reg);
            assign col_c   = 16'(col_reg);
            assign start_c = 16'(start_reg);
        end
    endgenerate

    assign col_sum  = {1'b0, col_reg} + (P+1)'((char_value == asl_pkg::CH_TAB)
                                               ? asl_pkg::TAB_STEP : 1);
    assign col_inc  = col_sum[P] ? '1 : col_sum[P-1:0];
    assign line_sum = {1'b0, line_reg} + (P+1)'(1);
    assign line_inc = line_sum[P] ? '1 : line_sum[P-1:0];

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    always_comb
    begin
        is_letter = (char_value inside {[asl_pkg::CH_LC_A : asl_pkg::CH_LC_Z],
                                        [asl_pkg::CH_UC_A : asl_pkg::CH_UC_Z],
                                        asl_pkg::CH_UNDER});
        is_dec    = (char_value inside {[asl_pkg::CH_ZERO : asl_pkg::CH_NINE]});
        is_hex    = is_dec
                  || (char_value inside {[asl_pkg::CH_LC_A : asl_pkg::CH_LC_F],
                                         [asl_pkg::CH_UC_A : asl_pkg::CH_UC_F]});
        is_bin    = (char_value inside {asl_pkg::CH_ZERO, asl_pkg::CH_ONE});
        is_blank  = (char_value inside {asl_pkg::CH_SPACE, asl_pkg::CH_TAB,
                                        asl_pkg::CH_CR});
        in_token  = (mode_reg inside {asl_pkg::M_IDENT, asl_pkg::M_ZERO, asl_pkg::M_DEC,
                                      asl_pkg::M_HEX, asl_pkg::M_BIN});
        tok_type  = (mode_reg == asl_pkg::M_IDENT) ? asl_pkg::TYPE_IDENT
                                                   : asl_pkg::TYPE_INT;
    end

    // does the byte continue the current token
    always_comb
    begin
        cont_mode = asl_pkg::M_IDLE;
        case (mode_reg)
            asl_pkg::M_IDENT: cont_mode = (is_letter || is_dec) ? asl_pkg::M_IDENT
                                                                : asl_pkg::M_IDLE;
            asl_pkg::M_ZERO:
            begin
                if (char_value == asl_pkg::CH_LC_X)
                    cont_mode = asl_pkg::M_HEX;
                else if (char_value == asl_pkg::CH_LC_B)
                    cont_mode = asl_pkg::M_BIN;
                else if (is_dec)
                    cont_mode = asl_pkg::M_DEC;
            end
            asl_pkg::M_DEC:   cont_mode = is_dec ? asl_pkg::M_DEC : asl_pkg::M_IDLE;
            asl_pkg::M_HEX:   cont_mode = is_hex ? asl_pkg::M_HEX : asl_pkg::M_IDLE;
            asl_pkg::M_BIN:   cont_mode = is_bin ? asl_pkg::M_BIN : asl_pkg::M_IDLE;
            default:          cont_mode = asl_pkg::M_IDLE;
        endcase
    end

    // byte seen outside any token
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_rec   = '0;
        idle_mode  = asl_pkg::M_IDLE;
        idle_line  = line_reg;
        idle_col   = col_reg;
        idle_start = start_reg;
        if (is_blank)
        begin
            idle_col = col_inc;
        end
        else if (char_value == asl_pkg::CH_LF)
        begin
            idle_emit = 1'b1;
            idle_rec  = make_rec(asl_pkg::KIND_EOL, 1'b0, 8'd0, line_c, col_c, 2'd0);
            idle_line = line_inc;
            idle_col  = POS_ONE;
        end
        else if (is_letter)
        begin
            idle_emit  = 1'b1;
            idle_rec   = make_rec(asl_pkg::KIND_CHAR, asl_pkg::TYPE_IDENT, char_value,
                                  line_c, col_c, 2'd0);
            idle_start = col_reg;
            idle_mode  = asl_pkg::M_IDENT;
            idle_col   = col_inc;
        end
        else if (is_dec)
        begin
            idle_emit  = 1'b1;
            idle_rec   = make_rec(asl_pkg::KIND_CHAR, asl_pkg::TYPE_INT, char_value,
                                  line_c, col_c, 2'd0);
            idle_start = col_reg;
            idle_mode  = (char_value == asl_pkg::CH_ZERO) ? asl_pkg::M_ZERO
                                                          : asl_pkg::M_DEC;
            idle_col   = col_inc;
        end
        else if (char_value == asl_pkg::CH_SLASH)
        begin
            idle_mode = asl_pkg::M_SLASH;
            idle_col  = col_inc;
        end
        else
        begin
            idle_emit = 1'b1;
            idle_rec  = make_rec(asl_pkg::KIND_ERROR, 1'b0, 8'd0, line_c, col_c,
                                 asl_pkg::ERR_UNEXPECTED);
            idle_mode = asl_pkg::M_HALT;
        end
    end

    always_comb
    begin
        n_res      = 2'd0;
        rec0       = '0;
        rec1       = '0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        if (mode_reg == asl_pkg::M_HALT)
        begin
            n_res = 2'd0;
        end
        else if (end_of_input)
        begin
            if (in_token)
            begin
                n_res = 2'd1;
                rec0  = make_rec(asl_pkg::KIND_END, tok_type, 8'd0, line_c, start_c, 2'd0);
            end
            else if (mode_reg == asl_pkg::M_SLASH)
            begin
                n_res = 2'd1;
                rec0  = make_rec(asl_pkg::KIND_ERROR, 1'b0, 8'd0, line_c, col_c,
                                 asl_pkg::ERR_SLASH);
            end
            else if (mode_reg == asl_pkg::M_BLOCK || mode_reg == asl_pkg::M_BSTAR)
            begin
                n_res = 2'd1;
                rec0  = make_rec(asl_pkg::KIND_ERROR, 1'b0, 8'd0, line_c, col_c,
                                 asl_pkg::ERR_BLOCK);
            end
            if (mode_reg == asl_pkg::M_SLASH || mode_reg == asl_pkg::M_BLOCK
                || mode_reg == asl_pkg::M_BSTAR)
            begin
                mode_next = asl_pkg::M_HALT;
            end
            else
            begin
                mode_next  = asl_pkg::M_IDLE;
                line_next  = POS_ONE;
                col_next   = POS_ONE;
                start_next = POS_ONE;
            end
        end
        else if (in_token)
        begin
            if (cont_mode != asl_pkg::M_IDLE)
            begin
                n_res     = 2'd1;
                rec0      = make_rec(asl_pkg::KIND_CHAR, tok_type, char_value,
                                     line_c, col_c, 2'd0);
                mode_next = cont_mode;
                col_next  = col_inc;
            end
            else
            begin
                rec0       = make_rec(asl_pkg::KIND_END, tok_type, 8'd0, line_c,
                                      start_c, 2'd0);
                rec1       = idle_rec;
                n_res      = idle_emit ? 2'd2 : 2'd1;
                mode_next  = idle_mode;
                line_next  = idle_line;
                col_next   = idle_col;
                start_next = idle_start;
            end
        end
        else if (mode_reg == asl_pkg::M_SLASH)
        begin
            if (char_value == asl_pkg::CH_SLASH)
            begin
                mode_next = asl_pkg::M_LINE;
                col_next  = col_inc;
            end
            else if (char_value == asl_pkg::CH_STAR)
            begin
                mode_next = asl_pkg::M_BLOCK;
                col_next  = col_inc;
            end
            else
            begin
                n_res     = 2'd1;
                rec0      = make_rec(asl_pkg::KIND_ERROR, 1'b0, 8'd0, line_c, col_c,
                                     asl_pkg::ERR_SLASH);
                mode_next = asl_pkg::M_HALT;
            end
        end
        else if (mode_reg == asl_pkg::M_LINE)
        begin
            if (char_value == asl_pkg::CH_LF)
            begin
                rec0       = idle_rec;
                n_res      = 2'd1;
                mode_next  = idle_mode;
                line_next  = idle_line;
                col_next   = idle_col;
                start_next = idle_start;
            end
            else
            begin
                col_next = col_inc;
            end
        end
        else if (mode_reg == asl_pkg::M_BLOCK || mode_reg == asl_pkg::M_BSTAR)
        begin
            if (char_value == asl_pkg::CH_LF)
            begin
                line_next = line_inc;
                col_next  = POS_ONE;
                mode_next = asl_pkg::M_BLOCK;
            end
            else
            begin
                if (mode_reg == asl_pkg::M_BSTAR && char_value == asl_pkg::CH_SLASH)
                    mode_next = asl_pkg::M_IDLE;
                else if (char_value == asl_pkg::CH_STAR)
                    mode_next = asl_pkg::M_BSTAR;
                else
                    mode_next = asl_pkg::M_BLOCK;
                col_next = col_inc;
            end
        end
        else
        begin
            rec0       = idle_rec;
            n_res      = idle_emit ? 2'd1 : 2'd0;
            mode_next  = idle_mode;
            line_next  = idle_line;
            col_next   = idle_col;
            start_next = idle_start;
        end
    end

    assign push              = accept && (n_res != 2'd0);
    assign push_entry.first  = rec0;
    assign push_entry.second = rec1;
    assign push_entry.two    = (n_res == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= asl_pkg::M_IDLE;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            start_reg <= POS_ONE;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/asl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asl_queue: result record queue
// Short first-in first-out buffer between lexer front and output serialiser.
// ----------------------------------------------------------------------------
module asl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire asl_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output asl_pkg::head_t       head
);

    asl_pkg::entry_t store_reg [asl_pkg::QUEUE_DEPTH];
    logic [asl_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [asl_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [asl_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full       = (cnt_reg == asl_pkg::QCNT_W'(asl_pkg::QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.entry = store_reg[rd_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + asl_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = do_pop  ? rd_reg + asl_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + asl_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - asl_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/asl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asl_back: output serialiser
// Sends the one or two results of the head record, one per request,
// marking the last one, and releases the record after it.
// ----------------------------------------------------------------------------
module asl_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire asl_pkg::head_t head,
    output logic                pop,
    output logic                tok_valid,
    input  wire logic           tok_stall,
    output logic [1:0]          result_kind,
    output logic                token_type,
    output logic [7:0]          token_char,
    output logic [15:0]         line_number,
    output logic [15:0]         column_number,
    output logic [1:0]          error_code,
    output logic                last_result
);

    logic sel_reg, sel_next;
    logic accept;
    asl_pkg::result_t cur;

    assign cur         = sel_reg ? head.entry.second : head.entry.first;
    assign tok_valid   = head.valid;
    assign last_result = sel_reg || !head.entry.two;
    assign accept      = tok_valid && !tok_stall;
    assign pop         = accept && last_result;

    assign result_kind   = cur.kind;
    assign token_type    = cur.ttype;
    assign token_char    = cur.tchar;
    assign line_number   = cur.line;
    assign column_number = cur.col;
    assign error_code    = cur.err;

    always_comb
    begin
        sel_next = sel_reg;
        if (accept)
            sel_next = !last_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule
`default_nettype wire

>>> rtl/assembly_source_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_source_lexer: byte-serial tokeniser for assembly source
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+----------------------------------------
//   source  | src_valid  | src_stall  | char_value, end_of_input
//   tokens  | tok_valid  | tok_stall  | result_kind .. last_result
//
// One byte is taken per cycle while src_stall is low; its results are registered
// in the queue and leave it one result per cycle while tok_stall is low, so a
// byte that ends a token and starts a new one gives two results in turn.
// A four-record queue separates the lexer front from the output serialiser;
// src_stall rises only while that queue is full.
// Reset puts the lexer at line 1, column 1, with the queue empty.
// ----------------------------------------------------------------------------
module assembly_source_lexer #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_stall,
    input  wire logic [7:0]  char_value,
    input  wire logic        end_of_input,
    output logic             tok_valid,
    input  wire logic        tok_stall,
    output logic [1:0]       result_kind,
    output logic             token_type,
    output logic [7:0]       token_char,
    output logic [15:0]      line_number,
    output logic [15:0]      column_number,
    output logic [1:0]       error_code,
    output logic             last_result
);

    logic q_full, q_push, q_pop;
    asl_pkg::entry_t q_entry;
    asl_pkg::head_t  q_head;

    asl_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .char_value   (char_value),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .push         (q_push),
        .push_entry   (q_entry)
    );

    asl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head       (q_head)
    );

    asl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .result_kind   (result_kind),
        .token_type    (token_type),
        .token_char    (token_char),
        .line_number   (line_number),
        .column_number (column_number),
        .error_code    (error_code),
        .last_result   (last_result)
    );

`ifndef ASSERT_OFF
    // no record is offered to a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("record pushed into full queue");

    // the second result of a pair follows the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_stall && !last_result) |=> (tok_valid && last_result))
        else $error("second result of pair missing");

    // an error always closes the results of its byte
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && result_kind == asl_pkg::KIND_ERROR) |-> last_result)
        else $error("error result not last");

    // after an error the front falls silent
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.first.kind == asl_pkg::KIND_ERROR) |=> !q_push)
        else $error("result produced after error");
`endif

endmodule
`default_nettype wire

>>> verif/token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: predicts and checks the token results of the lexer
// Tracks its own copy of the lexer state on every accepted source request,
// queues the token results that request must give, and compares each
// accepted token result with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    input  logic        src_stall,
    input  logic [7:0]  char_value,
    input  logic        end_of_input,
    input  logic        tok_valid,
    input  logic        tok_stall,
    input  logic [1:0]  result_kind,
    input  logic        token_type,
    input  logic [7:0]  token_char,
    input  logic [15:0] line_number,
    input  logic [15:0] column_number,
    input  logic [1:0]  error_code,
    input  logic        last_result,
    output int          mismatches,
    output int          outstanding,
    output int          tokens_checked
);

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [7:0] NO_CHAR  = 8'h00;

    typedef struct packed {
        asl_pkg::result_t res;
        logic             last;
    } token_t;

    asl_pkg::mode_t lex_mode;
    logic [15:0]    cur_line;
    logic [15:0]    cur_col;
    logic [15:0]    tok_col;
    token_t         expected_tokens[$];
    token_t         step_out[2];
    int             step_n;

    function automatic logic [15:0] pos_add(input logic [15:0] v, input logic [2:0] d);
        logic [16:0] s;
        s = {1'b0, v} + {14'd0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= asl_pkg::CH_LC_A && c <= asl_pkg::CH_LC_Z)
            || (c >= asl_pkg::CH_UC_A && c <= asl_pkg::CH_UC_Z)
            || c == asl_pkg::CH_UNDER;
    endfunction

    function automatic bit is_dec_char(input logic [7:0] c);
        return c >= asl_pkg::CH_ZERO && c <= asl_pkg::CH_NINE;
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return is_dec_char(c)
            || (c >= asl_pkg::CH_LC_A && c <= asl_pkg::CH_LC_F)
            || (c >= asl_pkg::CH_UC_A && c <= asl_pkg::CH_UC_F);
    endfunction

    function automatic bit in_token();
        return lex_mode >= asl_pkg::M_IDENT && lex_mode <= asl_pkg::M_BIN;
    endfunction

    function automatic logic mode_type();
        return (lex_mode == asl_pkg::M_IDENT) ? asl_pkg::TYPE_IDENT : asl_pkg::TYPE_INT;
    endfunction

    // mode after c if it continues the token, idle otherwise
    function automatic asl_pkg::mode_t next_mode(input logic [7:0] c);
        case (lex_mode)
            asl_pkg::M_IDENT:
                return (is_letter(c) || is_dec_char(c)) ? asl_pkg::M_IDENT : asl_pkg::M_IDLE;
            asl_pkg::M_ZERO:
            begin
                if (c == asl_pkg::CH_LC_X)
                    return asl_pkg::M_HEX;
                if (c == asl_pkg::CH_LC_B)
                    return asl_pkg::M_BIN;
                return is_dec_char(c) ? asl_pkg::M_DEC : asl_pkg::M_IDLE;
            end
            asl_pkg::M_DEC:
                return is_dec_char(c) ? asl_pkg::M_DEC : asl_pkg::M_IDLE;
            asl_pkg::M_HEX:
                return is_hex(c) ? asl_pkg::M_HEX : asl_pkg::M_IDLE;
            asl_pkg::M_BIN:
                return (c == asl_pkg::CH_ZERO || c == asl_pkg::CH_ONE) ? asl_pkg::M_BIN
                                                                     : asl_pkg::M_IDLE;
            default:
                return asl_pkg::M_IDLE;
        endcase
    endfunction

    task automatic step_col(input logic [7:0] c);
        cur_col = pos_add(cur_col, (c == asl_pkg::CH_TAB) ? 3'(asl_pkg::TAB_STEP) : 3'd1);
    endtask

    task automatic add_result(input asl_pkg::kind_t kind, input logic ttype,
                              input logic [7:0] tchar, input logic [15:0] col,
                              input logic [1:0] err);
        token_t t;
        t.res.kind  = kind;
        t.res.ttype = ttype;
        t.res.tchar = tchar;
        t.res.line  = cur_line;
        t.res.col   = col;
        t.res.err   = err;
        t.last      = 1'b0;
        step_out[step_n] = t;
        step_n++;
    endtask

    // a byte seen with no token or comment open
    task automatic lex_fresh(input logic [7:0] c);
        if (c == asl_pkg::CH_SPACE || c == asl_pkg::CH_TAB || c == asl_pkg::CH_CR)
        begin
            step_col(c);
        end
        else if (c == asl_pkg::CH_LF)
        begin
            add_result(asl_pkg::KIND_EOL, asl_pkg::TYPE_IDENT, NO_CHAR, cur_col, ERR_NONE);
            cur_line = pos_add(cur_line, 3'd1);
            cur_col  = 16'd1;
        end
        else if (is_letter(c) || is_dec_char(c))
        begin
            tok_col = cur_col;
            if (is_letter(c))
            begin
                add_result(asl_pkg::KIND_CHAR, asl_pkg::TYPE_IDENT, c, cur_col, ERR_NONE);
                lex_mode = asl_pkg::M_IDENT;
            end
            else
            begin
                add_result(asl_pkg::KIND_CHAR, asl_pkg::TYPE_INT, c, cur_col, ERR_NONE);
                lex_mode = (c == asl_pkg::CH_ZERO) ? asl_pkg::M_ZERO : asl_pkg::M_DEC;
            end
            step_col(c);
        end
        else if (c == asl_pkg::CH_SLASH)
        begin
            lex_mode = asl_pkg::M_SLASH;
            step_col(c);
        end
        else
        begin
            add_result(asl_pkg::KIND_ERROR, asl_pkg::TYPE_IDENT, NO_CHAR, cur_col,
                       asl_pkg::ERR_UNEXPECTED);
            lex_mode = asl_pkg::M_HALT;
        end
    endtask

    task automatic predict_request(input logic [7:0] c, input logic eoi);
        asl_pkg::mode_t nxt;
        token_t         t;
        int             i;
        step_n = 0;
        if (lex_mode == asl_pkg::M_HALT)
        begin
            // halted: silent until reset
        end
        else if (eoi)
        begin
            if (in_token())
            begin
                add_result(asl_pkg::KIND_END, mode_type(), NO_CHAR, tok_col, ERR_NONE);
            end
            else if (lex_mode == asl_pkg::M_SLASH)
            begin
                add_result(asl_pkg::KIND_ERROR, asl_pkg::TYPE_IDENT, NO_CHAR, cur_col,
                           asl_pkg::ERR_SLASH);
                lex_mode = asl_pkg::M_HALT;
            end
            else if (lex_mode == asl_pkg::M_BLOCK || lex_mode == asl_pkg::M_BSTAR)
            begin
                add_result(asl_pkg::KIND_ERROR, asl_pkg::TYPE_IDENT, NO_CHAR, cur_col,
                           asl_pkg::ERR_BLOCK);
                lex_mode = asl_pkg::M_HALT;
            end
            if (lex_mode != asl_pkg::M_HALT)
            begin
                lex_mode = asl_pkg::M_IDLE;
                cur_line = 16'd1;
                cur_col  = 16'd1;
                tok_col  = 16'd1;
            end
        end
        else if (in_token())
        begin
            nxt = next_mode(c);
            if (nxt != asl_pkg::M_IDLE)
            begin
                add_result(asl_pkg::KIND_CHAR, mode_type(), c, cur_col, ERR_NONE);
                lex_mode = nxt;
                step_col(c);
            end
            else
            begin
                add_result(asl_pkg::KIND_END, mode_type(), NO_CHAR, tok_col, ERR_NONE);
                lex_mode = asl_pkg::M_IDLE;
                lex_fresh(c);
            end
        end
        else if (lex_mode == asl_pkg::M_SLASH)
        begin
            if (c == asl_pkg::CH_SLASH)
            begin
                lex_mode = asl_pkg::M_LINE;
                step_col(c);
            end
            else if (c == asl_pkg::CH_STAR)
            begin
                lex_mode = asl_pkg::M_BLOCK;
                step_col(c);
            end
            else
            begin
                add_result(asl_pkg::KIND_ERROR, asl_pkg::TYPE_IDENT, NO_CHAR, cur_col,
                           asl_pkg::ERR_SLASH);
                lex_mode = asl_pkg::M_HALT;
            end
        end
        else if (lex_mode == asl_pkg::M_LINE)
        begin
            if (c == asl_pkg::CH_LF)
            begin
                lex_mode = asl_pkg::M_IDLE;
                lex_fresh(c);
            end
            else
            begin
                step_col(c);
            end
        end
        else if (lex_mode == asl_pkg::M_BLOCK || lex_mode == asl_pkg::M_BSTAR)
        begin
            if (c == asl_pkg::CH_LF)
            begin
                cur_line = pos_add(cur_line, 3'd1);
                cur_col  = 16'd1;
                lex_mode = asl_pkg::M_BLOCK;
            end
            else
            begin
                if (lex_mode == asl_pkg::M_BSTAR && c == asl_pkg::CH_SLASH)
                    lex_mode = asl_pkg::M_IDLE;
                else if (c == asl_pkg::CH_STAR)
                    lex_mode = asl_pkg::M_BSTAR;
                else
                    lex_mode = asl_pkg::M_BLOCK;
                step_col(c);
            end
        end
        else
        begin
            lex_mode = asl_pkg::M_IDLE;
            lex_fresh(c);
        end
        for (i = 0; i < step_n; i++)
        begin
            t      = step_out[i];
            t.last = (i == step_n - 1);
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token result with nothing expected: kind %0d line %0d column %0d",
                   result_kind, line_number, column_number);
            mismatches++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            compare_field("result_kind", 16'(want.res.kind), 16'(result_kind));
            compare_field("token_type", 16'(want.res.ttype), 16'(token_type));
            compare_field("token_char", 16'(want.res.tchar), 16'(token_char));
            compare_field("line_number", want.res.line, line_number);
            compare_field("column_number", want.res.col, column_number);
            compare_field("error_code", 16'(want.res.err), 16'(error_code));
            compare_field("last_result", 16'(want.last), 16'(last_result));
        end
        tokens_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode = asl_pkg::M_IDLE;
            cur_line = 16'd1;
            cur_col  = 16'd1;
            tok_col  = 16'd1;
            expected_tokens.delete();
            outstanding = 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                predict_request(char_value, end_of_input);
            if (tok_valid && !tok_stall)
                check_result();
            outstanding = expected_tokens.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: source stream stimulus for the assembly source lexer
// Feeds directed and randomly built assembly text, one byte per request,
// under three idling mixes, then ends on one randomly chosen halting
// error. Checking sits in token_checker; this module only drives and
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        END_UNEXPECTED,
        END_BAD_SLASH,
        END_SLASH_EOI,
        END_OPEN_BLOCK
    } ending_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        src_valid    = 1'b0;
    logic        src_stall;
    logic [7:0]  char_value   = 8'h00;
    logic        end_of_input = 1'b0;
    logic        tok_valid;
    logic        tok_stall    = 1'b0;
    logic [1:0]  result_kind;
    logic        token_type;
    logic [7:0]  token_char;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [1:0]  error_code;
    logic        last_result;

    int      mismatches;
    int      outstanding;
    int      tokens_checked;
    int      sender_idle_pct   = 35;
    int      receiver_idle_pct = 86;
    int      items_sent        = 0;
    int      quiet_cycles      = 0;
    ending_t ending;

    assembly_source_lexer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .char_value   (char_value),
        .end_of_input (end_of_input),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .result_kind  (result_kind),
        .token_type   (token_type),
        .token_char   (token_char),
        .line_number  (line_number),
        .column_number(column_number),
        .error_code   (error_code),
        .last_result  (last_result)
    );

    token_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .char_value    (char_value),
        .end_of_input  (end_of_input),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .result_kind   (result_kind),
        .token_type    (token_type),
        .token_char    (token_char),
        .line_number   (line_number),
        .column_number (column_number),
        .error_code    (error_code),
        .last_result   (last_result),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .tokens_checked(tokens_checked)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        tok_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // no request or token result for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push(input logic [7:0] c, input logic eoi);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid    <= 1'b1;
        char_value   <= c;
        end_of_input <= eoi;
        @(negedge clk);
        while (src_stall)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push(s[i], 1'b0);
    endtask

    task automatic push_eoi();
        push(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold off until every predicted token result is out
    task automatic drain();
        src_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(negedge clk);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_ident_start();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(asl_pkg::CH_LC_A + r);
        if (r < 52)
            return 8'(asl_pkg::CH_UC_A + (r - 26));
        return asl_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit(input int lo);
        return 8'(asl_pkg::CH_ZERO + $urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'(asl_pkg::CH_ZERO + r);
        if (r < 16)
            return 8'(asl_pkg::CH_LC_A + (r - 10));
        return 8'(asl_pkg::CH_UC_A + (r - 16));
    endfunction

    function automatic bit starts_cleanly(input logic [7:0] b);
        return (b >= asl_pkg::CH_LC_A && b <= asl_pkg::CH_LC_Z)
            || (b >= asl_pkg::CH_UC_A && b <= asl_pkg::CH_UC_Z)
            || b == asl_pkg::CH_UNDER
            || (b >= asl_pkg::CH_ZERO && b <= asl_pkg::CH_NINE)
            || b == asl_pkg::CH_SLASH || b == asl_pkg::CH_SPACE || b == asl_pkg::CH_TAB
            || b == asl_pkg::CH_CR || b == asl_pkg::CH_LF;
    endfunction

    // one well-formed piece of source, glued straight onto the previous one
    task automatic send_fragment();
        int         sel;
        int         len;
        int         i;
        logic [7:0] b;
        logic [7:0] prev;
        sel = $urandom_range(0, 19);
        len = $urandom_range(0, 6);
        if (sel <= 3)
        begin
            push(pick_ident_start(), 1'b0);
            for (i = 0; i < len; i++)
                push(($urandom_range(0, 4) == 0) ? pick_digit(0) : pick_ident_start(), 1'b0);
        end
        else if (sel <= 5)
        begin
            push(pick_digit(1), 1'b0);
            for (i = 0; i < len; i++)
                push(pick_digit(0), 1'b0);
        end
        else if (sel == 6)
        begin
            push(asl_pkg::CH_ZERO, 1'b0);
        end
        else if (sel == 7)
        begin
            push(asl_pkg::CH_ZERO, 1'b0);
            push(asl_pkg::CH_LC_X, 1'b0);
            for (i = 0; i < len % 5; i++)
                push(pick_hex(), 1'b0);
        end
        else if (sel == 8)
        begin
            push(asl_pkg::CH_ZERO, 1'b0);
            push(asl_pkg::CH_LC_B, 1'b0);
            for (i = 0; i < len; i++)
                push(($urandom_range(0, 1) == 0) ? asl_pkg::CH_ZERO : asl_pkg::CH_ONE, 1'b0);
        end
        else if (sel == 9)
        begin
            push(asl_pkg::CH_ZERO, 1'b0);
            for (i = 0; i <= len % 3; i++)
                push(pick_digit(0), 1'b0);
        end
        else if (sel <= 12)
        begin
            b = ($urandom_range(0, 2) == 0) ? asl_pkg::CH_TAB
                                            : (sel == 12 ? asl_pkg::CH_CR : asl_pkg::CH_SPACE);
            push(b, 1'b0);
        end
        else if (sel <= 14)
        begin
            push(asl_pkg::CH_LF, 1'b0);
        end
        else if (sel == 15)
        begin
            push(asl_pkg::CH_SLASH, 1'b0);
            push(asl_pkg::CH_SLASH, 1'b0);
            for (i = 0; i < $urandom_range(0, 8); i++)
            begin
                b = 8'($urandom_range(0, 255));
                push((b == asl_pkg::CH_LF) ? asl_pkg::CH_SPACE : b, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                push_eoi();
            else
                push(asl_pkg::CH_LF, 1'b0);
        end
        else if (sel == 16)
        begin
            push(asl_pkg::CH_SLASH, 1'b0);
            push(asl_pkg::CH_STAR, 1'b0);
            prev = asl_pkg::CH_SPACE;
            for (i = 0; i < $urandom_range(0, 8); i++)
            begin
                case ($urandom_range(0, 3))
                    0:       b = asl_pkg::CH_STAR;
                    1:       b = asl_pkg::CH_LF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                // keep the comment open until its proper close
                if (prev == asl_pkg::CH_STAR && b == asl_pkg::CH_SLASH)
                    b = asl_pkg::CH_STAR;
                push(b, 1'b0);
                prev = b;
            end
            push(asl_pkg::CH_STAR, 1'b0);
            push(asl_pkg::CH_SLASH, 1'b0);
        end
        else if (sel == 17)
        begin
            push_eoi();
        end
        else
        begin
            push(asl_pkg::CH_SPACE, 1'b0);
        end
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
        begin
            send_fragment();
            if ($urandom_range(0, 59) == 0)
                drain();
        end
        drain();
    endtask

    task automatic run_halt();
        logic [7:0] b;
        int         i;
        ending = ending_t'($urandom_range(0, 3));
        push_text("mov r1");
        case (ending)
            END_UNEXPECTED:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (starts_cleanly(b));
                push(b, 1'b0);
            end
            END_BAD_SLASH:
            begin
                push(asl_pkg::CH_SLASH, 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == asl_pkg::CH_SLASH || b == asl_pkg::CH_STAR);
                push(b, 1'b0);
            end
            END_SLASH_EOI:
            begin
                push(asl_pkg::CH_SLASH, 1'b0);
                push_eoi();
            end
            default:
            begin
                push_text("/*x*");
                push(asl_pkg::CH_LF, 1'b0);
                push_eoi();
            end
        endcase
        // after the halt nothing may come out
        for (i = 0; i < 5; i++)
            push(8'($urandom_range(0, 255)), 1'b0);
        push_eoi();
        push_text("z9");
        drain();
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);

        // extremes of every token class, comments and blanks
        push_text("_z9 0xaF");
        push(asl_pkg::CH_TAB, 1'b0);
        push_text("0b1");
        push(asl_pkg::CH_CR, 1'b0);
        push_text("07//");
        push(8'hFF, 1'b0);
        push(8'h00, 1'b0);
        push(asl_pkg::CH_LF, 1'b0);
        push_text("/**");
        push(asl_pkg::CH_LF, 1'b0);
        push_text("*/0x");
        push_eoi();
        drain();

        run_random(400);
        set_idling(86, 35);
        run_random(780);
        set_idling(0, 0);
        run_random(1150);
        run_halt();

        repeat (20) @(posedge clk);
        $display("covered %0d source requests and %0d token results over three idling mixes",
                 items_sent, tokens_checked);
        $display("comments, all token classes and the halt reached by %s", ending.name());
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
